@@ design/vhsa_pkg.sv @@
`default_nettype none
package vhsa_pkg;
	localparam int NUM_OUTPUTS_DEF = 16;
	localparam int SLOTS_PER_OUTPUT_DEF = 64;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int FUNC_W = 3;
	localparam int IDX_W = 4;
	localparam int HANDLE_W = 16;
	localparam int CAP_W = 7;
	localparam int VALUE_W = 16;

	typedef enum logic [FUNC_W-1:0] {
		FN_OPEN_OUTPUT = 3'd0,
		FN_ALLOC_SAMPLE = 3'd1,
		FN_LOOKUP_SAMPLE = 3'd2,
		FN_OPEN_STREAM = 3'd3,
		FN_START_STREAM = 3'd4,
		FN_RELEASE_SAMPLE = 3'd5
	} func_t;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;
endpackage
`default_nettype wire

@@ design/vhsa_ram.sv @@
`default_nettype none
module vhsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/voice_handle_slot_allocator.sv @@
// channel  | handshake              | payload
// in       | in_valid / in_stall    | func out_index handle capacity device_ok
// out      | out_valid / out_stall  | status value
// cfg      | cfg_we                 | cfg_wdata (driver_installed)
// After reset a clearing pass over all NUM_OUTPUTS*SLOTS_PER_OUTPUT entries
// zeroes both handle tables; in_stall stays high meanwhile.
// open_output clears both handle tables of the opened output.
// alloc/open_stream scan the entries of one output for a free one.
// lookup/start/release scan open outputs, one entry per cycle from the RAM
// read port.
// One request at a time; a held result waits in the output register.
`default_nettype none
module voice_handle_slot_allocator import vhsa_pkg::*; #(
	parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF,
	parameter int SLOTS_PER_OUTPUT = SLOTS_PER_OUTPUT_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [FUNC_W-1:0] func,
	input wire logic [IDX_W-1:0] out_index,
	input wire logic [HANDLE_W-1:0] handle,
	input wire logic [CAP_W-1:0] capacity,
	input wire logic device_ok,
	output logic out_valid,
	input wire logic out_stall,
	output logic status,
	output logic [VALUE_W-1:0] value
);
	localparam int OB = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
	localparam int EB = (SLOTS_PER_OUTPUT > 1) ? $clog2(SLOTS_PER_OUTPUT) : 1;
	localparam int DEPTH = NUM_OUTPUTS * SLOTS_PER_OUTPUT;
	localparam int AB = OB + EB;
	localparam int RAM_DEPTH = 1 << AB;
	localparam int CW = $clog2(SLOTS_PER_OUTPUT + 1);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_WIPE = 6'b000100,
		ST_SCAN = 6'b001000,
		ST_DONE = 6'b010000,
		ST_HOLD = 6'b100000
	} state_t;

	state_t state_q;
	logic cfg_q;
	logic [NUM_OUTPUTS-1:0] open_q;
	logic [CW-1:0] cap_q [NUM_OUTPUTS];
	logic [CW-1:0] cnt_q [NUM_OUTPUTS];
	logic [FUNC_W-1:0] func_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [OB-1:0] o_q;
	logic [EB:0] e_q;
	logic [AB:0] clr_q;
	logic rd_s1;
	logic [OB-1:0] ro_s1;
	logic [EB-1:0] re_s1;
	logic stat_q;
	logic [VALUE_W-1:0] val_q;
	logic ovalid_q;

	logic we;
	logic [AB-1:0] waddr, raddr;
	logic [HANDLE_BITS-1:0] wdata, rd_samp, rd_strm;
	logic we_samp, we_strm;
	logic use_strm;
	logic [HANDLE_BITS-1:0] rd;
	logic first_closed_found;
	logic [OB-1:0] first_closed;
	logic [HANDLE_BITS-1:0] h_in;

	assign h_in = HANDLE_BITS'(handle);
	assign use_strm = (func_q == FN_OPEN_STREAM) || (func_q == FN_START_STREAM);
	assign rd = use_strm ? rd_strm : rd_samp;
	assign we_samp = we && (state_q != ST_WIPE ? !use_strm : 1'b1);
	assign we_strm = we && (state_q != ST_WIPE ? use_strm : 1'b1);

	vhsa_ram #(.WIDTH(HANDLE_BITS), .DEPTH(RAM_DEPTH)) u_samp (
		.clk(clk), .we(we_samp || (state_q == ST_CLEAR)), .waddr(waddr),
		.wdata(wdata), .raddr(raddr), .rdata(rd_samp));
	vhsa_ram #(.WIDTH(HANDLE_BITS), .DEPTH(RAM_DEPTH)) u_strm (
		.clk(clk), .we(we_strm || (state_q == ST_CLEAR)), .waddr(waddr),
		.wdata(wdata), .raddr(raddr), .rdata(rd_strm));

	always_comb begin
		first_closed_found = 1'b0;
		first_closed = '0;
		for (int i = NUM_OUTPUTS - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				first_closed_found = 1'b1;
				first_closed = OB'(i);
			end
		end
	end

	// entry address; reads walk with e_q, scan writes target the checked entry
	assign raddr = (AB)'(o_q) * (AB)'(SLOTS_PER_OUTPUT) + (AB)'(e_q[EB-1:0]);

	always_comb begin
		we = 1'b0;
		waddr = (AB)'(ro_s1) * (AB)'(SLOTS_PER_OUTPUT) + (AB)'(re_s1);
		wdata = '0;
		if (state_q == ST_CLEAR) begin
			waddr = clr_q[AB-1:0];
		end else if (state_q == ST_WIPE) begin
			we = 1'b1;
			waddr = raddr;
		end else if (state_q == ST_SCAN && rd_s1 && rd == hnd_q) begin
			if (func_q == FN_ALLOC_SAMPLE || func_q == FN_OPEN_STREAM) begin
				we = 1'b1;
				wdata = HANDLE_BITS'(val_q);
			end else if (func_q == FN_RELEASE_SAMPLE) begin
				we = 1'b1;
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE) || (ovalid_q && out_stall);
	assign out_valid = ovalid_q;
	assign status = stat_q;
	assign value = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cfg_q <= 1'b0;
			open_q <= '0;
			clr_q <= '0;
			ovalid_q <= 1'b0;
			rd_s1 <= 1'b0;
			for (int i = 0; i < NUM_OUTPUTS; i++) begin
				cap_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			rd_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AB+1)'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						func_q <= func;
						hnd_q <= h_in;
						e_q <= '0;
						stat_q <= STATUS_FAIL;
						val_q <= '0;
						state_q <= ST_DONE;
						case (func)
							FN_OPEN_OUTPUT: begin
								if (cfg_q && device_ok && first_closed_found) begin
									o_q <= first_closed;
									cap_q[first_closed] <= (32'(capacity) > SLOTS_PER_OUTPUT)
										? CW'(SLOTS_PER_OUTPUT) : CW'(capacity);
									cnt_q[first_closed] <= '0;
									open_q[first_closed] <= 1'b1;
									stat_q <= STATUS_OK;
									val_q <= VALUE_W'(first_closed);
									state_q <= ST_WIPE;
								end
							end
							FN_ALLOC_SAMPLE, FN_OPEN_STREAM: begin
								// search for a free entry
								hnd_q <= '0;
								val_q <= VALUE_W'(h_in);
								o_q <= OB'(out_index);
								if (cfg_q && device_ok && 32'(out_index) < NUM_OUTPUTS
									&& open_q[OB'(out_index)]
									&& cnt_q[OB'(out_index)] < cap_q[OB'(out_index)]) begin
									state_q <= ST_SCAN;
								end
							end
							FN_LOOKUP_SAMPLE, FN_RELEASE_SAMPLE: begin
								o_q <= '0;
								state_q <= ST_SCAN;
							end
							FN_START_STREAM: begin
								o_q <= '0;
								if (cfg_q) begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WIPE: begin
					e_q <= e_q + 1'b1;
					if (e_q == (EB+1)'(SLOTS_PER_OUTPUT - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (rd_s1 && rd == hnd_q) begin
						state_q <= ST_DONE;
						stat_q <= STATUS_OK;
						case (func_q)
							FN_ALLOC_SAMPLE, FN_OPEN_STREAM: begin
								cnt_q[ro_s1] <= cnt_q[ro_s1] + 1'b1;
							end
							FN_LOOKUP_SAMPLE: begin
								val_q <= VALUE_W'(re_s1);
							end
							FN_RELEASE_SAMPLE: begin
								if (cnt_q[ro_s1] != '0) begin
									cnt_q[ro_s1] <= cnt_q[ro_s1] - 1'b1;
								end
							end
							default: begin
							end
						endcase
					end else if (open_q[o_q] && (CW)'(e_q) < cap_q[o_q]) begin
						rd_s1 <= 1'b1;
						ro_s1 <= o_q;
						re_s1 <= e_q[EB-1:0];
						e_q <= e_q + 1'b1;
					end else if ((func_q == FN_ALLOC_SAMPLE || func_q == FN_OPEN_STREAM)
						|| 32'(o_q) == NUM_OUTPUTS - 1) begin
						if (!rd_s1) begin
							state_q <= ST_DONE;
							val_q <= '0;
						end
					end else if (!rd_s1 || 1'b1) begin
						o_q <= o_q + 1'b1;
						e_q <= '0;
					end
				end
				ST_DONE: begin
					if (!ovalid_q || !out_stall) begin
						if (stat_q == STATUS_FAIL) begin
							val_q <= '0;
						end
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/vhsa_checker.sv @@
`default_nettype none
module vhsa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic status,
	input wire logic [15:0] value
);
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> value == 16'd0) else $error("fail value");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value)) else $error("hold");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("busy");
endmodule
bind voice_handle_slot_allocator vhsa_checker u_vhsa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status), .value(value));
`default_nettype wire
